[hw/rtl/u2da_pkg.sv]
// Shared constants and the power-of-ten table for the decimal ASCII converter.
// No dependencies.
package u2da_pkg;

  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned ROOM_W     = 8;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned IDX_W      = 4;   // digit position 0..MAX_DIGITS-1
  localparam int unsigned QBIT_W     = 2;   // quotient bit 3..0 within a digit
  localparam int unsigned OPND_W     = VAL_W + 4;  // power of ten shifted up to x8

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;

  typedef logic [VAL_W-1:0] val_t;

  // Power of ten for a digit position; unused codes map to one.
  function automatic val_t pow10(input logic [IDX_W-1:0] k);
    val_t p;
    case (k)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

[hw/rtl/uint_to_decimal_ascii_top.sv]
// Unsigned 32-bit to decimal ASCII converter, top level.
// Depends on u2da_pkg (power-of-ten table, widths, ASCII base).
//
// For each request the digit count is found by scanning down from the highest power of ten,
// then each digit is produced by restoring division, one quotient bit at a time, and its
// character is held until the receiver takes it; when there is no room a single no-room
// result is sent instead.
// One request is processed at a time.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops any result.
module uint_to_decimal_ascii_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // [31:0] value, [39:32] room
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [6:0] digit_char, [7] zero fill
  output logic        out_tlast,   // last_char
  output logic        out_tuser    // no_room
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_COUNT = 2'd1;
  localparam logic [1:0] ST_DIGIT = 2'd2;
  localparam logic [1:0] ST_SEND  = 2'd3;

  logic [1:0]                     state_r, state_nxt;
  u2da_pkg::val_t                 val_r, val_nxt;
  logic [u2da_pkg::ROOM_W-1:0]    room_r, room_nxt;
  logic [u2da_pkg::IDX_W-1:0]     k_r, k_nxt;
  logic [u2da_pkg::QBIT_W-1:0]    s_r, s_nxt;
  logic [3:0]                     q_r, q_nxt;
  logic [u2da_pkg::CHAR_W-1:0]    char_r, char_nxt;
  logic                           last_r, last_nxt;
  logic                           noroom_r, noroom_nxt;

  // Shared compare/subtract unit: remainder minus a power of ten, shifted left while dividing.
  logic [u2da_pkg::OPND_W-1:0]    opnd;
  logic [u2da_pkg::OPND_W:0]      diff;
  logic                           ge;
  logic [u2da_pkg::IDX_W-1:0]     ndig;
  logic [3:0]                     q_new;

  always_comb begin
    opnd = {4'd0, u2da_pkg::pow10(k_r)};
    if (state_r == ST_DIGIT) begin
      opnd = opnd << s_r;
    end
    diff = {1'b0, 4'd0, val_r} - {1'b0, opnd};
    ge   = ~diff[u2da_pkg::OPND_W];
  end

  assign ndig  = k_r + 4'd1;
  assign q_new = q_r | (ge ? (4'd1 << s_r) : 4'd0);

  always_comb begin
    state_nxt  = state_r;
    val_nxt    = val_r;
    room_nxt   = room_r;
    k_nxt      = k_r;
    s_nxt      = s_r;
    q_nxt      = q_r;
    char_nxt   = char_r;
    last_nxt   = last_r;
    noroom_nxt = noroom_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          val_nxt   = in_tdata[31:0];
          room_nxt  = in_tdata[39:32];
          k_nxt     = 4'(u2da_pkg::MAX_DIGITS - 1);
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        // Scan from the top power down; the first hit sets the digit count.
        if (ge || k_r == 4'd0) begin
          if ({4'd0, ndig} > room_r) begin
            char_nxt   = '0;
            last_nxt   = 1'b1;
            noroom_nxt = 1'b1;
            state_nxt  = ST_SEND;
          end else begin
            s_nxt     = 2'd3;
            q_nxt     = 4'd0;
            state_nxt = ST_DIGIT;
          end
        end else begin
          k_nxt = k_r - 4'd1;
        end
      end
      ST_DIGIT: begin
        // One quotient bit per cycle: subtract 8p, 4p, 2p, p when it fits.
        if (ge) begin
          val_nxt = diff[u2da_pkg::VAL_W-1:0];
        end
        q_nxt = q_new;
        if (s_r == 2'd0) begin
          char_nxt   = u2da_pkg::ASCII_ZERO + {3'd0, q_new};
          last_nxt   = (k_r == 4'd0);
          noroom_nxt = 1'b0;
          state_nxt  = ST_SEND;
        end else begin
          s_nxt = s_r - 2'd1;
        end
      end
      ST_SEND: begin
        // Hold the character until taken, then advance to the next digit, or return to idle after the last one.
        if (out_tready) begin
          if (last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r - 4'd1;
            s_nxt     = 2'd3;
            q_nxt     = 4'd0;
            state_nxt = ST_DIGIT;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    val_r    <= val_nxt;
    room_r   <= room_nxt;
    k_r      <= k_nxt;
    s_r      <= s_nxt;
    q_r      <= q_nxt;
    char_r   <= char_nxt;
    last_r   <= last_nxt;
    noroom_r <= noroom_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_SEND);
  assign out_tdata  = {1'b0, char_r};
  assign out_tlast  = last_r;
  assign out_tuser  = noroom_r;

endmodule

[dv/tb_top.sv]
// Self-checking testbench for uint_to_decimal_ascii_top.
// Drives value/room requests, predicts the ASCII digit stream and checks it.
// Depends on u2da_pkg (widths, ASCII base, value type).
module tb_top;

  localparam int unsigned MAX_DIGITS = u2da_pkg::MAX_DIGITS;
  localparam int unsigned ROOM_W     = u2da_pkg::ROOM_W;
  localparam int unsigned CHAR_W     = u2da_pkg::CHAR_W;
  localparam logic [u2da_pkg::CHAR_W-1:0] ASCII_ZERO = u2da_pkg::ASCII_ZERO;

  typedef u2da_pkg::val_t val_t;

  // One expected or observed result: a character, its last flag, the no-room flag.
  typedef struct packed {
    logic [CHAR_W-1:0] digit;
    logic              last;
    logic              no_room;
  } dec_char_t;

  // Directed stimulus row; has_want marks a row whose single result is typed in.
  typedef struct packed {
    val_t              value;
    logic [ROOM_W-1:0] room;
    logic              has_want;
    dec_char_t         want;
  } dir_row_t;

  localparam int unsigned NUM_DIRECTED  = 20;
  localparam int unsigned ITEMS_PER_PH  = 50;
  localparam int unsigned NUM_PHASES    = 4;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned DRAIN_CYCLES  = 80;

  localparam dec_char_t NO_ROOM_CHAR = '{digit: '0, last: 1'b1, no_room: 1'b1};

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata   = '0;   // [31:0] value, [39:32] room
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;         // [6:0] digit_char, [7] zero fill
  logic              out_tlast;         // last_char
  logic              out_tuser;         // no_room

  dec_char_t   expected_chars[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;

  // Extremes, zero, several digit-count boundaries and the no-room cases.
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{32'd0,          8'd1,   1'b1, '{ASCII_ZERO, 1'b1, 1'b0}},
    '{32'd0,          8'd0,   1'b1, NO_ROOM_CHAR},
    '{32'd0,          8'd255, 1'b1, '{ASCII_ZERO, 1'b1, 1'b0}},
    '{32'd9,          8'd1,   1'b1, '{ASCII_ZERO + 7'd9, 1'b1, 1'b0}},
    '{32'd10,         8'd1,   1'b1, NO_ROOM_CHAR},
    '{32'd10,         8'd2,   1'b0, '0},
    '{32'd99,         8'd2,   1'b0, '0},
    '{32'd100,        8'd2,   1'b1, NO_ROOM_CHAR},
    '{32'd100,        8'd3,   1'b0, '0},
    '{32'd12345,      8'd5,   1'b0, '0},
    '{32'd1000000,    8'd7,   1'b0, '0},
    '{32'd999999999,  8'd9,   1'b0, '0},
    '{32'd999999999,  8'd255, 1'b0, '0},
    '{32'd1000000000, 8'd9,   1'b1, NO_ROOM_CHAR},
    '{32'd1000000000, 8'd10,  1'b0, '0},
    '{32'hFFFFFFFF,   8'd10,  1'b0, '0},
    '{32'hFFFFFFFF,   8'd9,   1'b1, NO_ROOM_CHAR},
    '{32'hFFFFFFFF,   8'd0,   1'b1, NO_ROOM_CHAR},
    '{32'hFFFFFFFF,   8'd255, 1'b0, '0},
    '{32'h80000000,   8'd128, 1'b0, '0}
  };

  uint_to_decimal_ascii_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #12000000;
    $display("Test completed with failures");
    $finish;
  end

  // Decimal digit count of a value, found by comparing against powers of ten.
  function automatic int unsigned digit_count(input val_t value);
    int unsigned n;
    logic [39:0] pw;
    n  = 1;
    pw = 40'd10;
    for (int k = 1; k < MAX_DIGITS; k++) begin
      if ({8'd0, value} >= pw) n = k + 1;
      pw = pw * 10;
    end
    return n;
  endfunction

  // Queue the characters one accepted request should produce.
  function automatic void predict_decimal_text(input val_t value, input logic [ROOM_W-1:0] room);
    int unsigned n;
    logic [3:0]  digits [MAX_DIGITS];
    val_t        rest;
    dec_char_t   c;
    n    = digit_count(value);
    rest = value;
    if (n > room) begin
      expected_chars.push_back(NO_ROOM_CHAR);
      return;
    end
    for (int i = 0; i < n; i++) begin
      digits[n - 1 - i] = 4'(rest % 10);
      rest = rest / 10;
    end
    for (int i = 0; i < n; i++) begin
      c.digit   = ASCII_ZERO + CHAR_W'(digits[i]);
      c.last    = (i + 1 == n);
      c.no_room = 1'b0;
      expected_chars.push_back(c);
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Offer one request, with random idle cycles first; return at the accepting edge.
  // The valid line is lowered only when a gap follows, so it never toggles in one step.
  task automatic send_request(input val_t value, input logic [ROOM_W-1:0] room);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {room, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Random value: mostly a chosen digit count with random content, some raw
  // 32-bit noise, some exact powers of ten and their neighbors.
  function automatic val_t pick_value();
    int unsigned k;
    logic [39:0] lo, hi;
    k  = $urandom_range(1, MAX_DIGITS);
    lo = 40'd1;
    for (int i = 1; i < k; i++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (hi > 40'hFFFFFFFF) hi = 40'hFFFFFFFF;
    if (k == 1) lo = 40'd0;
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return val_t'(hi);
      3:       return (k == 1) ? val_t'(0) : val_t'(lo);
      default: return $urandom_range(val_t'(hi), val_t'(lo));
    endcase
  endfunction

  // Room: mostly enough, some exactly one short, some anywhere in range.
  function automatic logic [ROOM_W-1:0] pick_room(input val_t value);
    int unsigned n;
    n = digit_count(value);
    case ($urandom_range(0, 9))
      0:       return ROOM_W'($urandom_range(0, 255));
      1:       return ROOM_W'(n - 1);
      2:       return ROOM_W'(n);
      3:       return ROOM_W'($urandom_range(n, 255));
      default: return ROOM_W'(n + $urandom_range(0, 4));
    endcase
  endfunction

  // Receiver: stall at the phase's rate, or hold off entirely during a pressure stretch.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Checker: compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    dec_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected result data=%h last=%b no_room=%b",
                                  out_tdata, out_tlast, out_tuser));
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata !== {1'b0, want.digit})
          report_mismatch($sformatf("digit_char got %h want %h", out_tdata, want.digit));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last_char got %b want %b", out_tlast, want.last));
        if (out_tuser !== want.no_room)
          report_mismatch($sformatf("no_room got %b want %b", out_tuser, want.no_room));
      end
    end
  end

  // Main sequence: reset, directed table, then random phases with varied idling.
  initial begin
    val_t              value;
    logic [ROOM_W-1:0] room;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling on either side.
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].value, directed_rows[i].room);
      if (directed_rows[i].has_want) expected_chars.push_back(directed_rows[i].want);
      else predict_decimal_text(directed_rows[i].value, directed_rows[i].room);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      // Hold the receiver off for a long stretch while requests keep coming,
      // so the block backs up and drops in_tready.
      if (ph == 0) hold_left = HOLD_CYCLES;
      for (int n = 0; n < ITEMS_PER_PH; n++) begin
        value = pick_value();
        room  = pick_room(value);
        send_request(value, room);
        predict_decimal_text(value, room);
      end
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every expected result, then watch for stray ones.
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
